// ===== src/rfc_pkg.sv =====
// Shared types, constants and register indexes of the row FIR convolution core.
package rfc_pkg;

    // Field widths
    localparam int SAMPLE_W       = 16;
    localparam int COEF_W         = 16;
    localparam int OUT_W          = 24;
    localparam int FRAC_W         = 12;
    localparam int NUM_TAPS       = 7;
    localparam int TAP_IDX_W      = 3;
    localparam int H_W            = 2;

    // Widths sized for the largest supported half width of three
    localparam int SHIFT_W        = 3;
    localparam int NRES_W         = 3;
    localparam int REP_W          = 2;
    localparam int ROW_CNT_W      = 3;
    localparam logic [ROW_CNT_W-1:0] ROW_CNT_MAX = '1;

    // Request queue between front and back
    localparam int QUEUE_DEPTH    = 2;

    // Configuration port
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    typedef enum logic [2:0] {
        REG_HALF_WIDTH,
        REG_COEF_0,
        REG_COEF_1,
        REG_COEF_2,
        REG_COEF_3,
        REG_COEF_4,
        REG_COEF_5,
        REG_COEF_6
    } t_reg_idx;

    localparam logic [H_W-1:0] HALF_WIDTH_RST = 2'd2;
    localparam logic [NUM_TAPS-1:0][COEF_W-1:0] COEF_RST = {
        16'd0, 16'd0, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0
    };

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       row_end;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic                    last_of_run;
    } t_out;

    typedef struct packed {
        logic [H_W-1:0]                   half_width;
        logic [NUM_TAPS-1:0][COEF_W-1:0]  coef;
    } t_cfg;

    // Per-request control: first window offset, result count, half width
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [NRES_W-1:0]  n_res;
        logic [H_W-1:0]     h;
    } t_cmd;

endpackage

// ===== src/row_fir_convolution_core.sv =====
// Top level of the row FIR convolution core: register file, front end, request queue, back end.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------
//  pixel     in         i_valid / o_stall    i_data  (sample, row_end)
//  result    out        o_valid / i_stall    o_data  (filtered, last_of_run)
//  config    in         APB psel/penable     paddr, pwdata, prdata
//
// One pixel is taken each cycle unless the queue is full; its request then passes the queue and the back pipeline.
// A row end releasing n results (up to MAX_HALF+1) keeps the back pipeline busy issuing them, and
// the next row's first h pixels send no request, so only a row shorter than h+1 pixels closing
// in that window fills the two-entry queue and stalls the input while i_stall stays low.
// Reset clears the window, row count, queue and pipeline valids and loads register defaults.
// i_stall freezes the whole back pipeline while a result is held; the front stalls only when the queue is full.
module row_fir_convolution_core #(
    parameter int MAX_HALF = 3
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  rfc_pkg::t_in               i_data,
    output logic                       o_stall,
    output logic                       o_valid,
    output rfc_pkg::t_out              o_data,
    input  logic                       i_stall,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [rfc_pkg::DATA_W-1:0] pwdata,
    output logic [rfc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int NL   = 2 * MAX_HALF + 1;
    localparam int QW   = NL * rfc_pkg::SAMPLE_W + $bits(rfc_pkg::t_cmd);
    localparam int CMDW = $bits(rfc_pkg::t_cmd);

    rfc_pkg::t_cfg                            s_cfg;
    logic                                     s_push;
    logic                                     s_pop;
    logic                                     s_q_full;
    logic                                     s_q_valid;
    logic [NL-1:0][rfc_pkg::SAMPLE_W-1:0]     s_lanes_in;
    logic [NL-1:0][rfc_pkg::SAMPLE_W-1:0]     s_lanes_out;
    rfc_pkg::t_cmd                            s_cmd_in;
    rfc_pkg::t_cmd                            s_cmd_out;
    logic [QW-1:0]                            s_q_din;
    logic [QW-1:0]                            s_q_dout;

    rfc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (s_cfg)
    );

    rfc_front #(
        .MAX_HALF (MAX_HALF)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_cfg    (s_cfg),
        .i_q_full (s_q_full),
        .o_push   (s_push),
        .o_lanes  (s_lanes_in),
        .o_cmd    (s_cmd_in)
    );

    // Pack and unpack requests around the queue
    assign s_q_din     = {s_lanes_in, s_cmd_in};
    assign s_lanes_out = s_q_dout[QW-1:CMDW];
    assign s_cmd_out   = s_q_dout[CMDW-1:0];

    rfc_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_q_din),
        .o_full  (s_q_full),
        .i_pop   (s_pop),
        .o_valid (s_q_valid),
        .o_data  (s_q_dout)
    );

    rfc_back #(
        .MAX_HALF (MAX_HALF)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (s_q_valid),
        .i_lanes   (s_lanes_out),
        .i_cmd     (s_cmd_out),
        .i_cfg     (s_cfg),
        .o_pop     (s_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_data    (o_data)
    );

    // Results of one pixel leave back to back once the first is taken
    a_run_contiguous : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_data.last_of_run) |=> o_valid)
        else $error("result run broken before its last result");

    // The front never stalls while the queue is empty
    a_no_stall_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_q_valid |-> !o_stall)
        else $error("input stalled with an empty request queue");

    // No result right after reset
    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== src/rfc_cfg_regs.sv =====
// APB register file holding the half width and the seven kernel taps.
module rfc_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [rfc_pkg::ADDR_W-1:0] paddr,
    input  logic [rfc_pkg::DATA_W-1:0] pwdata,
    output logic [rfc_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output rfc_pkg::t_cfg             o_cfg
);

    logic [rfc_pkg::H_W-1:0]                            r_half_width;
    logic [rfc_pkg::NUM_TAPS-1:0][rfc_pkg::COEF_W-1:0]  r_coef;
    rfc_pkg::t_reg_idx                                  reg_idx;
    logic [rfc_pkg::TAP_IDX_W-1:0]                      tap_idx;
    logic                                               wr_en;

    // Decode the register index from the word address
    assign reg_idx = rfc_pkg::t_reg_idx'(paddr[rfc_pkg::ADDR_W-1:2]);
    assign tap_idx = rfc_pkg::TAP_IDX_W'(paddr[rfc_pkg::ADDR_W-1:2])
                   - rfc_pkg::TAP_IDX_W'(rfc_pkg::REG_COEF_0);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= rfc_pkg::HALF_WIDTH_RST;
            r_coef       <= rfc_pkg::COEF_RST;
        end else if (wr_en) begin
            if (reg_idx == rfc_pkg::REG_HALF_WIDTH) begin
                r_half_width <= pwdata[rfc_pkg::H_W-1:0];
            end else begin
                r_coef[tap_idx] <= pwdata[rfc_pkg::COEF_W-1:0];
            end
        end
    end

    // Read back, taps sign extended
    always_comb begin
        if (reg_idx == rfc_pkg::REG_HALF_WIDTH) begin
            prdata = rfc_pkg::DATA_W'(r_half_width);
        end else begin
            prdata = rfc_pkg::DATA_W'($signed(r_coef[tap_idx]));
        end
    end

    assign o_cfg.half_width = r_half_width;
    assign o_cfg.coef       = r_coef;

endmodule

// ===== src/rfc_front.sv =====
// Front end: sample window, row position and classification of each pixel into a request.
module rfc_front #(
    parameter int MAX_HALF = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  rfc_pkg::t_in          i_data,
    output logic                  o_stall,
    input  rfc_pkg::t_cfg         i_cfg,
    input  logic                  i_q_full,
    output logic                  o_push,
    output logic [2*MAX_HALF:0][rfc_pkg::SAMPLE_W-1:0] o_lanes,
    output rfc_pkg::t_cmd         o_cmd
);

    localparam int WIN = 2 * MAX_HALF;

    logic [rfc_pkg::SAMPLE_W-1:0]  r_window [WIN];
    logic [rfc_pkg::ROW_CNT_W-1:0] r_row_count;

    logic                          accept;
    logic [rfc_pkg::H_W-1:0]       h;
    logic [rfc_pkg::ROW_CNT_W:0]   cnt_p1;
    logic [rfc_pkg::ROW_CNT_W:0]   h_p1;
    logic [rfc_pkg::NRES_W-1:0]    n_res;
    logic [rfc_pkg::SHIFT_W-1:0]   shift;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;

    // Clamp the half width to what the window holds
    assign h = (i_cfg.half_width > rfc_pkg::H_W'(MAX_HALF)) ?
               rfc_pkg::H_W'(MAX_HALF) : i_cfg.half_width;

    assign cnt_p1 = {1'b0, r_row_count} + (rfc_pkg::ROW_CNT_W+1)'(1);
    assign h_p1   = (rfc_pkg::ROW_CNT_W+1)'(h) + (rfc_pkg::ROW_CNT_W+1)'(1);

    // Count results and locate the first output within the window
    always_comb begin
        if (i_data.row_end) begin
            n_res = (cnt_p1 < h_p1) ? rfc_pkg::NRES_W'(cnt_p1) : rfc_pkg::NRES_W'(h_p1);
            shift = rfc_pkg::SHIFT_W'(WIN + 1) - rfc_pkg::SHIFT_W'(n_res)
                  - rfc_pkg::SHIFT_W'(h);
        end else begin
            n_res = (r_row_count >= rfc_pkg::ROW_CNT_W'(h)) ?
                    rfc_pkg::NRES_W'(1) : rfc_pkg::NRES_W'(0);
            shift = rfc_pkg::SHIFT_W'(WIN) - rfc_pkg::SHIFT_W'({h, 1'b0});
        end
    end

    // Lay out oldest sample at lane 0, current sample at the top lane
    always_comb begin
        for (int j = 0; j < WIN; j++) begin
            o_lanes[j] = r_window[WIN-1-j];
        end
        o_lanes[WIN] = i_data.sample;
    end

    assign o_push      = accept && (n_res != '0);
    assign o_cmd.shift = shift;
    assign o_cmd.n_res = n_res;
    assign o_cmd.h     = h;

    // Advance the window, or drop it at a row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WIN; j++) begin
                r_window[j] <= '0;
            end
            r_row_count <= '0;
        end else if (accept) begin
            if (i_data.row_end) begin
                for (int j = 0; j < WIN; j++) begin
                    r_window[j] <= '0;
                end
                r_row_count <= '0;
            end else begin
                for (int j = 1; j < WIN; j++) begin
                    r_window[j] <= r_window[j-1];
                end
                r_window[0] <= i_data.sample;
                if (r_row_count != rfc_pkg::ROW_CNT_MAX) begin
                    r_row_count <= r_row_count + rfc_pkg::ROW_CNT_W'(1);
                end
            end
        end
    end

endmodule

// ===== src/rfc_queue.sv =====
// Short register queue carrying requests from the front end to the back end.
module rfc_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int DEPTH = rfc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Store requests
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/rfc_back.sv =====
// Back end: issues each request's results one per cycle while not stalled, through a multiply, add and round pipeline.
module rfc_back #(
    parameter int MAX_HALF = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  logic [2*MAX_HALF:0][rfc_pkg::SAMPLE_W-1:0] i_lanes,
    input  rfc_pkg::t_cmd         i_cmd,
    input  rfc_pkg::t_cfg         i_cfg,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output rfc_pkg::t_out         o_data
);

    localparam int WIN      = 2 * MAX_HALF;
    localparam int NL       = WIN + 1;
    localparam int NP       = (NL + 1) / 2;
    localparam int PROD_W   = rfc_pkg::SAMPLE_W + rfc_pkg::COEF_W;
    localparam int PAIR_W   = PROD_W + 1;
    localparam int ACC_W    = PAIR_W + $clog2(NP);
    localparam int MIN_RND  = rfc_pkg::OUT_W + rfc_pkg::FRAC_W + 1;
    localparam int RND_W    = (ACC_W + 1 > MIN_RND) ? ACC_W + 1 : MIN_RND;
    localparam int Q_W      = RND_W - rfc_pkg::FRAC_W;
    localparam int OUT_TOP  = rfc_pkg::OUT_W - 1;
    localparam int ROUND_HALF = 2 ** (rfc_pkg::FRAC_W - 1);
    localparam logic [rfc_pkg::OUT_W-1:0] SAT_MAX = {1'b0, {(rfc_pkg::OUT_W-1){1'b1}}};
    localparam logic [rfc_pkg::OUT_W-1:0] SAT_MIN = {1'b1, {(rfc_pkg::OUT_W-1){1'b0}}};

    logic                          adv;
    logic                          issue;
    logic                          rep_last;
    logic [rfc_pkg::REP_W-1:0]     r_rep;
    logic [rfc_pkg::SHIFT_W-1:0]   shift;
    logic [rfc_pkg::TAP_IDX_W-1:0] tap_lim;
    logic [rfc_pkg::TAP_IDX_W-1:0] tap_sh;

    logic [NL+WIN-1:0][rfc_pkg::SAMPLE_W-1:0]          ext;
    logic [NL+WIN-1:0][rfc_pkg::SAMPLE_W-1:0]          ext_sh;
    logic [rfc_pkg::NUM_TAPS-1:0][rfc_pkg::COEF_W-1:0] crev;
    logic [rfc_pkg::NUM_TAPS-1:0][rfc_pkg::COEF_W-1:0] crev_sh;
    logic signed [rfc_pkg::COEF_W-1:0]                 cf   [NL];
    logic signed [PROD_W-1:0]                          prod [NL];
    logic signed [PAIR_W-1:0]                          pair [NP];

    logic signed [PROD_W-1:0] r_prod [NL];
    logic                     r_v1;
    logic                     r_l1;
    logic signed [PAIR_W-1:0] r_pair [NP];
    logic                     r_v2;
    logic                     r_l2;
    logic                     r_o_valid;
    rfc_pkg::t_out            r_o_data;

    logic signed [ACC_W-1:0]  acc;
    logic signed [RND_W-1:0]  rnd;
    logic [Q_W-1:0]           q;
    logic [Q_W-OUT_TOP-1:0]   q_top;
    logic [rfc_pkg::OUT_W-1:0] sat;

    // Whole pipeline moves unless a finished result is held
    assign adv      = !r_o_valid || !i_stall;
    assign issue    = i_q_valid && adv;
    assign rep_last = (rfc_pkg::NRES_W'(r_rep) == i_cmd.n_res - rfc_pkg::NRES_W'(1));
    assign o_pop    = issue && rep_last;

    // Step through the results of the head request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep <= '0;
        end else if (issue) begin
            r_rep <= rep_last ? '0 : r_rep + rfc_pkg::REP_W'(1);
        end
    end

    // Align samples: zeros stand beyond the current pixel
    assign shift  = i_cmd.shift + rfc_pkg::SHIFT_W'(r_rep);
    assign ext    = {{(WIN*rfc_pkg::SAMPLE_W){1'b0}}, i_lanes};
    assign ext_sh = ext >> (shift * rfc_pkg::SAMPLE_W);

    // Flip the kernel and slide it so tap 2h lands on lane 0
    assign tap_lim = {i_cmd.h, 1'b0};
    assign tap_sh  = rfc_pkg::TAP_IDX_W'(rfc_pkg::NUM_TAPS - 1) - tap_lim;
    always_comb begin
        for (int m = 0; m < rfc_pkg::NUM_TAPS; m++) begin
            crev[m] = i_cfg.coef[rfc_pkg::NUM_TAPS-1-m];
        end
    end
    assign crev_sh = crev >> (tap_sh * rfc_pkg::COEF_W);

    // Multiply one lane each
    for (genvar j = 0; j < NL; j++) begin : g_lane
        assign cf[j]   = (rfc_pkg::TAP_IDX_W'(j) <= tap_lim) ? $signed(crev_sh[j]) : '0;
        assign prod[j] = $signed(ext_sh[j]) * cf[j];
    end

    // Add products in pairs
    for (genvar p = 0; p < NP; p++) begin : g_pair
        if (2 * p + 1 < NL) begin : g_two
            assign pair[p] = PAIR_W'(r_prod[2*p]) + PAIR_W'(r_prod[2*p+1]);
        end else begin : g_one
            assign pair[p] = PAIR_W'(r_prod[2*p]);
        end
    end

    // Final sum, round half up, saturate
    always_comb begin
        acc = '0;
        for (int p = 0; p < NP; p++) begin
            acc = acc + ACC_W'(r_pair[p]);
        end
        rnd   = RND_W'(acc) + RND_W'(ROUND_HALF);
        q     = rnd[RND_W-1:rfc_pkg::FRAC_W];
        q_top = q[Q_W-1:OUT_TOP];
        if ((&q_top) || !(|q_top)) begin
            sat = q[rfc_pkg::OUT_W-1:0];
        end else if (q[Q_W-1]) begin
            sat = SAT_MIN;
        end else begin
            sat = SAT_MAX;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_v1      <= issue;
            r_v2      <= r_v1;
            r_o_valid <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod                <= prod;
            r_l1                  <= rep_last;
            r_pair                <= pair;
            r_l2                  <= r_l1;
            r_o_data.filtered     <= sat;
            r_o_data.last_of_run  <= r_l2;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_data;

endmodule
